[src/rwnh_pkg.sv]
// Shared types and constants for the ray and wall nearest-hit search.
`default_nettype none
package rwnh_pkg;

    localparam int COORD_W = 24;
    localparam int DIR_W   = 16;
    localparam int DIFF_W  = 25;
    localparam int PROD_W  = 50;
    localparam int DEN_W   = 42;
    localparam int TNUM_W  = 51;
    localparam int QUOT_W  = 24;
    localparam int FRAC_W  = 14;
    localparam int SAT_SH  = 10;
    localparam int CNT_W   = 5;
    localparam int CFG_W   = 7;

    localparam logic [QUOT_W-1:0] DIST_NONE = '1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic [5:0]                wall_index;
        logic signed [COORD_W-1:0] wall_x1;
        logic signed [COORD_W-1:0] wall_y1;
        logic signed [COORD_W-1:0] wall_x2;
        logic signed [COORD_W-1:0] wall_y2;
        logic signed [COORD_W-1:0] ray_x;
        logic signed [COORD_W-1:0] ray_y;
        logic signed [DIR_W-1:0]   dir_cos;
        logic signed [DIR_W-1:0]   dir_sin;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic [QUOT_W-1:0] distance;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } t_wall;

    typedef struct packed {
        logic              start;
        logic [TNUM_W-1:0] num;
        logic [DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MS_DX_S,
        MS_DY_C,
        MS_OX_S,
        MS_OY_C,
        MS_DX_OY,
        MS_DY_OX,
        MS_LAST
    } t_mstep;

endpackage
`default_nettype wire

[src/rwnh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rwnh_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[src/rwnh_div.sv]
// Restoring divider, one quotient bit a cycle, for the scaled hit distance.
`default_nettype none
module rwnh_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rwnh_pkg::t_div_req i_req,
    output rwnh_pkg::t_div_rsp     o_rsp
);
    import rwnh_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_d;
    logic [QUOT_W-1:0] r_sh;
    logic [DEN_W:0]    trial;
    logic              qbit;
    logic [DEN_W-1:0]  rem_next;

    always_comb begin
        trial    = {r_rem, r_sh[QUOT_W-1]};
        qbit     = trial >= {1'b0, r_d};
        rem_next = qbit ? DEN_W'(trial - {1'b0, r_d}) : DEN_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
        // The numerator is num * 2^14; its top bits seed the remainder, which
        // stays below the divisor because the caller rules out overflow.
        if (i_req.start) begin
            r_cnt <= CNT_W'(QUOT_W - 1);
            r_rem <= DEN_W'(i_req.num[TNUM_W-1:SAT_SH]);
            r_sh  <= {i_req.num[SAT_SH-1:0], {FRAC_W{1'b0}}};
            r_d   <= i_req.den;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= rem_next;
            r_sh  <= {r_sh[QUOT_W-2:0], qbit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sh;
endmodule
`default_nettype wire

[src/ray_wall_nearest_hit.sv]
// Ray query against a RAM of wall segments, reporting the nearest hit distance.
// A load beat writes one wall into the table RAM. A query beat walks walls 0 to
// walls_in_use-1 (at most MAX_WALLS) one at a time through a single 25x25
// multiplier: each wall takes a table RAM read, the differences, six products and
// a hit test, then the bit-serial divider for a wall that is hit without
// saturating, and a finishing state ends the query. Input is taken only between
// items; a finished result waits in an output register.
`default_nettype none
module ray_wall_nearest_hit #(
    parameter int MAX_WALLS = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire rwnh_pkg::t_in_item i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output rwnh_pkg::t_out_item   o_out_data,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready
);
    import rwnh_pkg::*;

    localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CW = $clog2(MAX_WALLS + 1);

    t_state                    r_state, n_state;
    t_mstep                    r_step;
    logic [CFG_W-1:0]          r_walls;
    logic [CW-1:0]             r_idx, r_n;
    logic signed [COORD_W-1:0] r_rx, r_ry;
    logic signed [DIR_W-1:0]   r_c, r_s;
    logic signed [DIFF_W-1:0]  r_dx, r_dy, r_ox, r_oy;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DEN_W-1:0]   r_den, r_snum;
    logic signed [TNUM_W-1:0]  r_tnum;
    logic [QUOT_W-1:0]         r_best;
    logic                      r_any;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic                      in_acc, ram_we, ram_re, out_free, last_wall;
    logic [CW-1:0]             n_lim;
    logic [$bits(t_wall)-1:0]  ram_rdata;
    t_wall                     wall;
    logic signed [DIFF_W-1:0]  op_a, op_b;
    logic                      den_neg, s_ok, t_ok, hit_ok, sat;
    logic [TNUM_W-1:0]         mag_a;
    logic [DEN_W-1:0]          mag_d;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign ram_we   = in_acc && (i_in_data.req_type == REQ_LOAD)
                      && (32'(i_in_data.wall_index) < MAX_WALLS);
    assign n_lim    = (32'(r_walls) > MAX_WALLS) ? CW'(MAX_WALLS) : CW'(r_walls);
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_wall = (r_idx + 1'b1) == r_n;
    assign wall     = t_wall'(ram_rdata);

    rwnh_ram #(
        .WIDTH ($bits(t_wall)),
        .DEPTH (MAX_WALLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_in_data.wall_index)),
        .i_wdata ({i_in_data.wall_x1, i_in_data.wall_y1,
                   i_in_data.wall_x2, i_in_data.wall_y2}),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    rwnh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Hit test on the finished Cramer terms.
    always_comb begin
        den_neg = r_den[DEN_W-1];
        if (den_neg) begin
            s_ok = (r_snum <= 0) && (r_snum >= r_den);
        end else begin
            s_ok = (r_snum >= 0) && (r_snum <= r_den);
        end
        t_ok   = (r_tnum == 0) || (r_tnum[TNUM_W-1] != den_neg);
        hit_ok = (r_den != 0) && s_ok && t_ok;
        mag_a  = r_tnum[TNUM_W-1] ? TNUM_W'(-r_tnum) : TNUM_W'(r_tnum);
        mag_d  = den_neg ? DEN_W'(-r_den) : DEN_W'(r_den);
        sat    = {1'b0, mag_a} >= {mag_d, {SAT_SH{1'b0}}};
    end

    always_comb begin
        case (r_step)
            MS_DX_S:  begin op_a = r_dx; op_b = DIFF_W'(r_s); end
            MS_DY_C:  begin op_a = r_dy; op_b = DIFF_W'(r_c); end
            MS_OX_S:  begin op_a = r_ox; op_b = DIFF_W'(r_s); end
            MS_OY_C:  begin op_a = r_oy; op_b = DIFF_W'(r_c); end
            MS_DX_OY: begin op_a = r_dx; op_b = r_oy; end
            MS_DY_OX: begin op_a = r_dy; op_b = r_ox; end
            default:  begin op_a = '0;   op_b = '0; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_data.req_type == REQ_QUERY)) begin
                    n_state = (n_lim == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ:  n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_MUL;
            ST_MUL: begin
                if (r_step == MS_LAST) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (hit_ok && !sat) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = last_wall ? ST_DONE : ST_READ;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = last_wall ? ST_DONE : ST_READ;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall    = (r_state != ST_IDLE);
        ram_re        = (r_state == ST_READ);
        div_req.start = (r_state == ST_CHECK) && hit_ok && !sat;
        div_req.num   = mag_a;
        div_req.den   = mag_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_walls     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && !paddr[2]) begin
                r_walls <= pwdata[CFG_W-1:0];
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_rx   <= i_in_data.ray_x;
                r_ry   <= i_in_data.ray_y;
                r_c    <= i_in_data.dir_cos;
                r_s    <= i_in_data.dir_sin;
                r_n    <= n_lim;
                r_idx  <= '0;
                r_best <= DIST_NONE;
                r_any  <= 1'b0;
            end
            ST_DIFF: begin
                r_dx   <= DIFF_W'(wall.x2) - DIFF_W'(wall.x1);
                r_dy   <= DIFF_W'(wall.y2) - DIFF_W'(wall.y1);
                r_ox   <= DIFF_W'(r_rx) - DIFF_W'(wall.x1);
                r_oy   <= DIFF_W'(r_ry) - DIFF_W'(wall.y1);
                r_step <= MS_DX_S;
            end
            ST_MUL: begin
                r_prod <= op_a * op_b;
                if (r_step != MS_LAST) begin
                    r_step <= t_mstep'(r_step + 1'b1);
                end
                // Each product is folded in at the step after the one that forms it.
                case (r_step)
                    MS_DY_C:  r_den  <= DEN_W'(r_prod);
                    MS_OX_S:  r_den  <= r_den - DEN_W'(r_prod);
                    MS_OY_C:  r_snum <= DEN_W'(r_prod);
                    MS_DX_OY: r_snum <= r_snum - DEN_W'(r_prod);
                    MS_DY_OX: r_tnum <= TNUM_W'(r_prod);
                    MS_LAST:  r_tnum <= r_tnum - TNUM_W'(r_prod);
                    default:  ;
                endcase
            end
            ST_CHECK: begin
                if (hit_ok && sat) begin
                    r_any <= 1'b1;
                end
                if (!(hit_ok && !sat)) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    r_any <= 1'b1;
                    if (div_rsp.quot < r_best) begin
                        r_best <= div_rsp.quot;
                    end
                    r_idx <= r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out.hit      <= r_any;
                    r_out.distance <= r_best;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = paddr[2] ? 32'd0 : 32'(r_walls);

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result raised outside the finishing state");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ || r_state == ST_CHECK || r_state == ST_DIV) |-> r_idx < r_n)
        else $error("wall index ran past the searched count");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == ST_DIV)
        else $error("divider finished while not awaited");

    a_div_start_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> r_state == ST_DIV)
        else $error("divider started without waiting for it");
endmodule
`default_nettype wire

[sim/rwnh_checker.sv]
// Checker for the ray and wall nearest-hit search: predicts each query result and compares it.
module rwnh_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_stall,
    input  rwnh_pkg::t_in_item i_in_data,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_stall,
    input  rwnh_pkg::t_out_item i_out_data,
    input  wire logic          i_psel,
    input  wire logic          i_penable,
    input  wire logic          i_pwrite,
    input  wire logic          i_pready,
    input  wire logic [2:0]    i_paddr,
    input  wire logic [31:0]   i_pwdata,
    output int                 o_fails,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_hits
);
    import rwnh_pkg::*;

    localparam int NUM_WALLS = 64;
    localparam logic [2:0] ADDR_WALLS_IN_USE = 3'd0;

    t_wall          wall_mem [NUM_WALLS];
    logic [CFG_W-1:0] walls_searched;
    t_out_item      hit_q [$];
    int             fails;
    int             results;
    int             hits;

    assign o_fails   = fails;
    assign o_pending = hit_q.size();
    assign o_results = results;
    assign o_hits    = hits;

    function automatic t_out_item cast_ray(t_in_item q);
        longint rx, ry, c, s, dx, dy, ox, oy, den, snum, tnum;
        longint unsigned a, d, quo, rem, span, best;
        bit any, s_ok, t_ok;
        int n;
        t_out_item res;
        rx = q.ray_x;
        ry = q.ray_y;
        c = q.dir_cos;
        s = q.dir_sin;
        best = 64'hFFFFFF;
        any = 1'b0;
        n = (walls_searched > NUM_WALLS) ? NUM_WALLS : int'(walls_searched);
        for (int i = 0; i < n; i++) begin
            dx = longint'(wall_mem[i].x2) - longint'(wall_mem[i].x1);
            dy = longint'(wall_mem[i].y2) - longint'(wall_mem[i].y1);
            ox = rx - longint'(wall_mem[i].x1);
            oy = ry - longint'(wall_mem[i].y1);
            den = dx * s - dy * c;
            if (den == 0) continue;
            snum = ox * s - oy * c;
            tnum = dx * oy - dy * ox;
            if (den > 0) s_ok = (snum >= 0) && (snum <= den);
            else s_ok = (snum <= 0) && (snum >= den);
            t_ok = (tnum == 0) || ((tnum < 0) != (den < 0));
            if (!s_ok || !t_ok) continue;
            a = (tnum < 0) ? -tnum : tnum;
            d = (den < 0) ? -den : den;
            if (a >= (d << SAT_SH)) begin
                span = 64'hFFFFFF;
            end else begin
                quo = a / d;
                rem = a % d;
                span = (quo << FRAC_W) + ((rem << FRAC_W) / d);
                if (span > 64'hFFFFFF) span = 64'hFFFFFF;
            end
            if (!any || span < best) best = span;
            any = 1'b1;
        end
        res.hit = any;
        res.distance = any ? best[QUOT_W-1:0] : DIST_NONE;
        return res;
    endfunction

    initial begin
        fails = 0;
        results = 0;
        hits = 0;
        walls_searched = '0;
        for (int i = 0; i < NUM_WALLS; i++) wall_mem[i] = '0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            walls_searched = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (i_out_data.hit) hits++;
                if (hit_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result beat: hit=%0d distance=%h",
                                 i_out_data.hit, i_out_data.distance);
                end else begin
                    want = hit_q.pop_front();
                    if (want.hit !== i_out_data.hit
                        || want.distance !== i_out_data.distance) begin
                        fails++;
                        if (fails <= 10)
                            $display({"mismatch: expected hit=%0d distance=%h, ",
                                      "got hit=%0d distance=%h"},
                                     want.hit, want.distance,
                                     i_out_data.hit, i_out_data.distance);
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_WALLS_IN_USE)
                walls_searched = i_pwdata[CFG_W-1:0];
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.req_type == REQ_LOAD) begin
                    wall_mem[i_in_data.wall_index] = '{i_in_data.wall_x1, i_in_data.wall_y1,
                                                       i_in_data.wall_x2, i_in_data.wall_y2};
                end else begin
                    hit_q = {hit_q, cast_ray(i_in_data)};
                end
            end
        end
    end

endmodule

[sim/tb.sv]
// Testbench top for the ray and wall nearest-hit search: stimulus, back pressure and verdict.
module tb;
    import rwnh_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int LOAD_SETTLE = 30;
    localparam logic [2:0] ADDR_WALLS_IN_USE = 3'd0;
    localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;
    localparam logic signed [DIR_W-1:0] D_ONE = 16'sd16384;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_data;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int  fails, pending, results, hits;
    int  cycles;
    int  beats_sent;
    bit  tx_idle_on, rx_idle_on;
    bit  hold_go, hold_done;
    int  hold_cnt;

    ray_wall_nearest_hit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    rwnh_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fails(fails), .o_pending(pending), .o_results(results), .o_hits(hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off so the block backs up.
    initial begin
        out_stall = 1'b1;
        hold_cnt = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_cnt = 3000;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= rx_idle_on && ($urandom_range(99) < 28);
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4) return C_MAX;
        if (pick < 8) return C_MIN;
        if (pick < 10) return '0;
        if (pick < 70) return COORD_W'($signed($urandom_range(8192)) - 4096);
        return COORD_W'($urandom);
    endfunction

    function automatic logic signed [DIR_W-1:0] rand_dir();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) return D_ONE;
        if (pick < 16) return -D_ONE;
        if (pick < 20) return '0;
        return DIR_W'($signed($urandom_range(32768)) - 16384);
    endfunction

    function automatic t_in_item rand_beat(logic kind);
        t_in_item it;
        it = '0;
        it.req_type = kind;
        it.wall_index = 6'($urandom);
        it.wall_x1 = rand_coord();
        it.wall_y1 = rand_coord();
        it.wall_x2 = rand_coord();
        it.wall_y2 = rand_coord();
        it.ray_x = ($urandom_range(3) == 0) ? rand_coord()
                                            : COORD_W'($signed($urandom_range(512)) - 256);
        it.ray_y = ($urandom_range(3) == 0) ? rand_coord()
                                            : COORD_W'($signed($urandom_range(512)) - 256);
        it.dir_cos = rand_dir();
        it.dir_sin = rand_dir();
        return it;
    endfunction

    function automatic t_in_item wall_beat(int idx, logic signed [COORD_W-1:0] x1,
                                           logic signed [COORD_W-1:0] y1,
                                           logic signed [COORD_W-1:0] x2,
                                           logic signed [COORD_W-1:0] y2);
        t_in_item it;
        it = rand_beat(REQ_LOAD);
        it.wall_index = 6'(idx);
        it.wall_x1 = x1;
        it.wall_y1 = y1;
        it.wall_x2 = x2;
        it.wall_y2 = y2;
        return it;
    endfunction

    function automatic t_in_item ray_beat(logic signed [COORD_W-1:0] x,
                                          logic signed [COORD_W-1:0] y,
                                          logic signed [DIR_W-1:0] c,
                                          logic signed [DIR_W-1:0] s);
        t_in_item it;
        it = rand_beat(REQ_QUERY);
        it.ray_x = x;
        it.ray_y = y;
        it.dir_cos = c;
        it.dir_sin = s;
        return it;
    endfunction

    task automatic send(t_in_item it);
        while (tx_idle_on && $urandom_range(99) < 28) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    // Sender drops valid and waits until the block has drained every result.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LOAD_SETTLE) @(posedge i_clk);
    endtask

    task automatic set_walls(int n);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_WALLS_IN_USE;
        pwdata <= 32'(n);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(int n_walls, int n_beats);
        set_walls(n_walls);
        for (int k = 0; k < n_beats; k++)
            send(rand_beat(($urandom_range(99) < 75) ? REQ_QUERY : REQ_LOAD));
        drain();
    endtask

    initial begin
        int walls_list [12] = '{3, 5, 2, 8, 127, 1, 6, 64, 4, 7, 0, 3};
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_go = 1'b0;
        beats_sent = 0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No walls searched yet: the query must miss.
        set_walls(0);
        send(ray_beat(C_MAX, C_MIN, D_ONE, D_ONE));
        drain();

        // Fill the whole table so no search can reach an unwritten entry.
        send(wall_beat(0, 24'sd2560, -24'sd2560, 24'sd2560, 24'sd2560));
        send(wall_beat(1, C_MIN, C_MIN, C_MAX, C_MAX));
        send(wall_beat(2, '0, '0, '0, '0));
        send(wall_beat(3, C_MAX, C_MIN, C_MIN, C_MAX));
        for (int i = 4; i < 64; i++) send(wall_beat(i, rand_coord(), rand_coord(),
                                                    rand_coord(), rand_coord()));
        drain();

        set_walls(1);
        send(ray_beat('0, '0, D_ONE, '0));
        send(ray_beat('0, '0, -D_ONE, '0));
        send(ray_beat('0, '0, '0, D_ONE));
        send(ray_beat('0, '0, '0, '0));
        send(ray_beat(24'sd5120, 24'sd100, D_ONE, D_ONE));
        send(ray_beat(24'sd2560, '0, D_ONE, '0));
        drain();

        set_walls(4);
        send(ray_beat(C_MAX, C_MAX, -D_ONE, '0));
        send(ray_beat(C_MIN, C_MIN, D_ONE, -D_ONE));
        send(ray_beat(C_MAX, C_MIN, 16'sd1, '0));
        send(ray_beat('0, '0, -D_ONE, D_ONE));
        drain();

        set_walls(127);
        send(ray_beat('0, '0, D_ONE, 16'sd3));
        drain();

        for (int p = 0; p < 12; p++) begin
            tx_idle_on = (p != 5);
            rx_idle_on = (p != 5);
            if (p == 2) hold_go = 1'b1;
            run_phase(walls_list[p], (walls_list[p] >= 64) ? 10 : 33);
        end

        repeat (100) @(posedge i_clk);
        $display("tb: %0d beats sent, %0d query results checked, %0d of them hits,",
                 beats_sent, results, hits);
        $display("tb: walls searched from 0 up to beyond the table size, with back pressure");
        if (fails == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
